// ===== rtl/rhs_pkg.sv =====
package rhs_pkg;

    localparam int DEF_BUFFER_BYTES_LOG2 = 24;
    localparam int DEF_RECORD_ID_BITS    = 16;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MARK    = 3'd1;
    localparam logic [2:0] ST_NO_URLTOP   = 3'd2;
    localparam logic [2:0] ST_NO_URL      = 3'd3;
    localparam logic [2:0] ST_NO_TITLE    = 3'd4;
    localparam logic [2:0] ST_NO_TIME     = 3'd5;
    localparam logic [2:0] ST_NO_EOD      = 3'd6;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_D     = 8'h44;

    typedef struct packed {
        logic       is_hash;
        logic       is_space;
        logic       is_nl;
        logic       is_blank;
        logic       is_sign;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_e;
        logic       is_o;
        logic       is_d;
        logic       last;
    } t_cls;

    function automatic t_cls classify(input logic [7:0] c, input logic last);
        t_cls       r;
        logic [7:0] d;
        d          = c - CH_ZERO;
        r.is_hash  = (c == CH_HASH);
        r.is_space = (c == CH_SPACE);
        r.is_nl    = (c == CH_NL);
        r.is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
                     (c == CH_FF) || (c == CH_CR);
        r.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        r.is_minus = (c == CH_MINUS);
        r.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        r.digit    = d[3:0];
        r.is_e     = (c == CH_E);
        r.is_o     = (c == CH_O);
        r.is_d     = (c == CH_D);
        r.last     = last;
        return r;
    endfunction

endpackage

// ===== rtl/record_header_splitter.sv =====
// A byte's result, if any, passes from a queue entry to the output register; a
// stalled output can hold the byte in the queue before the parser takes it.
// Throughput: one byte per cycle while the output is not stalled, set by the
// header parser's per-byte update (phase step, field counter, times-ten time accumulate).
// A two-entry queue separates byte classification from the parser; an output
// register holds a result while the parser keeps going, unless that result is stalled.
// Reset (i_rst_n low, synchronous): queue emptied, parser to hash-mark phase,
// offsets and record ids zero.
module record_header_splitter import rhs_pkg::*; #(
    parameter int BUFFER_BYTES_LOG2 = DEF_BUFFER_BYTES_LOG2,
    parameter int RECORD_ID_BITS    = DEF_RECORD_ID_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_text_byte,
    input  logic                         i_buffer_end,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [RECORD_ID_BITS-1:0]    o_record_id,
    output logic [BUFFER_BYTES_LOG2-1:0] o_record_start,
    output logic [BUFFER_BYTES_LOG2-1:0] o_urltop_length,
    output logic [BUFFER_BYTES_LOG2-1:0] o_url_length,
    output logic [BUFFER_BYTES_LOG2-1:0] o_title_length,
    output logic [31:0]                  o_fetch_time,
    output logic [BUFFER_BYTES_LOG2-1:0] o_body_start,
    output logic [BUFFER_BYTES_LOG2-1:0] o_body_len,
    output logic [BUFFER_BYTES_LOG2-1:0] o_record_size
);

    logic w_q_valid;
    logic w_pop;
    t_cls w_q_item;

    rhs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_text_byte  (i_text_byte),
        .i_buffer_end (i_buffer_end),
        .o_stall      (o_stall),
        .i_pop        (w_pop),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item)
    );

    rhs_back #(
        .BUFFER_BYTES_LOG2 (BUFFER_BYTES_LOG2),
        .RECORD_ID_BITS    (RECORD_ID_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_record_id     (o_record_id),
        .o_record_start  (o_record_start),
        .o_urltop_length (o_urltop_length),
        .o_url_length    (o_url_length),
        .o_title_length  (o_title_length),
        .o_fetch_time    (o_fetch_time),
        .o_body_start    (o_body_start),
        .o_body_len      (o_body_len),
        .o_record_size   (o_record_size)
    );

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_urltop_length == '0 && o_url_length == '0 && o_title_length == '0 &&
             o_fetch_time == 32'd0 && o_body_len == '0 && o_record_size == '0))
        else $error("error result carries nonzero fields");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_q_valid)
        else $error("input stalled with empty queue");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_q_valid && (!o_valid || !i_stall)))
        else $error("parser popped without item or output room");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output valid or stall after reset");

endmodule

// ===== rtl/rhs_front.sv =====
module rhs_front import rhs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_buffer_end,
    output logic       o_stall,
    input  logic       i_pop,
    output logic       o_q_valid,
    output t_cls       o_q_item
);

    t_cls       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;

    assign o_stall   = (r_count == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= classify(i_text_byte, i_buffer_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/rhs_back.sv =====
module rhs_back import rhs_pkg::*; #(
    parameter int BUFFER_BYTES_LOG2 = DEF_BUFFER_BYTES_LOG2,
    parameter int RECORD_ID_BITS    = DEF_RECORD_ID_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  t_cls                         i_q_item,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic [RECORD_ID_BITS-1:0]    o_record_id,
    output logic [BUFFER_BYTES_LOG2-1:0] o_record_start,
    output logic [BUFFER_BYTES_LOG2-1:0] o_urltop_length,
    output logic [BUFFER_BYTES_LOG2-1:0] o_url_length,
    output logic [BUFFER_BYTES_LOG2-1:0] o_title_length,
    output logic [31:0]                  o_fetch_time,
    output logic [BUFFER_BYTES_LOG2-1:0] o_body_start,
    output logic [BUFFER_BYTES_LOG2-1:0] o_body_len,
    output logic [BUFFER_BYTES_LOG2-1:0] o_record_size
);

    localparam int P  = BUFFER_BYTES_LOG2;
    localparam int ID = RECORD_ID_BITS;

    localparam logic [3:0] PH_HASH   = 4'd0;
    localparam logic [3:0] PH_SPACE  = 4'd1;
    localparam logic [3:0] PH_URLTOP = 4'd2;
    localparam logic [3:0] PH_URL    = 4'd3;
    localparam logic [3:0] PH_TITLE  = 4'd4;
    localparam logic [3:0] PH_TIME   = 4'd5;
    localparam logic [3:0] PH_BODY   = 4'd6;
    localparam logic [3:0] PH_TAIL   = 4'd7;
    localparam logic [3:0] PH_SKIP   = 4'd8;

    localparam logic [1:0] TS_BLANK  = 2'd0;
    localparam logic [1:0] TS_SIGN   = 2'd1;
    localparam logic [1:0] TS_DIGITS = 2'd2;
    localparam logic [1:0] TS_DONE   = 2'd3;

    logic [3:0]    r_phase, n_phase;
    logic [P-1:0]  r_pos, n_pos;
    logic [P-1:0]  r_origin, n_origin;
    logic [ID-1:0] r_cnt, n_cnt;
    logic [P-1:0]  r_field, n_field;
    logic [P-1:0]  r_ut, n_ut;
    logic [P-1:0]  r_u, n_u;
    logic [P-1:0]  r_t, n_t;
    logic [31:0]   r_acc, n_acc;
    logic [1:0]    r_ts, n_ts;
    logic          r_neg, n_neg;
    logic [P-1:0]  r_body, n_body;
    logic [2:0]    r_eod, n_eod;

    logic          r_out_valid;
    logic [2:0]    r_o_status;
    logic [ID-1:0] r_o_id;
    logic [P-1:0]  r_o_start, r_o_ut, r_o_u, r_o_t, r_o_bstart, r_o_bsize, r_o_rsize;
    logic [31:0]   r_o_time;

    logic          w_pop;
    logic          w_emit;
    logic          w_ok;
    logic          w_late;
    logic [2:0]    w_code;
    logic [P-1:0]  w_bsize;
    logic [P-1:0]  w_rsize;
    t_cls          c;

    assign c     = i_q_item;
    assign w_pop = i_q_valid && (!r_out_valid || !i_stall);
    assign o_pop = w_pop;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_origin = r_origin;
        n_cnt    = r_cnt;
        n_field  = r_field;
        n_ut     = r_ut;
        n_u      = r_u;
        n_t      = r_t;
        n_acc    = r_acc;
        n_ts     = r_ts;
        n_neg    = r_neg;
        n_body   = r_body;
        n_eod    = r_eod;
        w_emit   = 1'b0;
        w_ok     = 1'b0;
        w_late   = 1'b0;
        w_code   = ST_OK;
        if (w_pop) begin
            unique case (r_phase)
                PH_HASH: begin
                    n_origin = r_pos;
                    n_field  = '0;
                    n_ut     = '0;
                    n_u      = '0;
                    n_t      = '0;
                    n_acc    = '0;
                    n_ts     = TS_BLANK;
                    n_neg    = 1'b0;
                    n_body   = '0;
                    n_eod    = '0;
                    if (c.is_hash) begin
                        n_phase = PH_SPACE;
                    end else begin
                        w_emit  = 1'b1;
                        w_code  = ST_BAD_MARK;
                        n_phase = PH_SKIP;
                    end
                end
                PH_SPACE: begin
                    if (c.is_space) begin
                        n_phase = PH_URLTOP;
                        n_field = '0;
                    end else begin
                        w_emit  = 1'b1;
                        w_code  = ST_BAD_MARK;
                        n_phase = PH_SKIP;
                    end
                end
                PH_URLTOP, PH_URL, PH_TITLE: begin
                    if (c.is_space) begin
                        if (r_phase == PH_URLTOP) begin
                            n_ut = r_field;
                        end else if (r_phase == PH_URL) begin
                            n_u = r_field;
                        end else begin
                            n_t = r_field;
                        end
                        n_field = '0;
                        n_phase = r_phase + 4'd1;
                    end else begin
                        n_field = r_field + P'(1);
                    end
                end
                PH_TIME: begin
                    if (c.is_nl) begin
                        if (r_neg) begin
                            n_acc = 32'd0 - r_acc;
                        end
                        n_body  = r_pos + P'(1);
                        n_eod   = '0;
                        n_phase = PH_BODY;
                    end else if (c.is_digit && r_ts != TS_DONE) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {28'd0, c.digit};
                        n_ts  = TS_DIGITS;
                    end else if (r_ts == TS_BLANK && c.is_blank) begin
                        n_ts = r_ts;
                    end else if (r_ts == TS_BLANK && c.is_sign) begin
                        n_neg = c.is_minus;
                        n_ts  = TS_SIGN;
                    end else begin
                        n_ts = TS_DONE;
                    end
                end
                PH_BODY: begin
                    if (c.is_nl) begin
                        n_eod = 3'd1;
                    end else if (r_eod == 3'd1 && c.is_e) begin
                        n_eod = 3'd2;
                    end else if (r_eod == 3'd2 && c.is_o) begin
                        n_eod = 3'd3;
                    end else if (r_eod == 3'd3 && c.is_d) begin
                        n_eod   = 3'd4;
                        n_phase = PH_TAIL;
                    end else begin
                        n_eod = '0;
                    end
                end
                PH_TAIL: begin
                    w_emit  = 1'b1;
                    w_ok    = 1'b1;
                    n_phase = PH_HASH;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (c.last) begin
                if (!w_emit) begin
                    unique case (n_phase)
                        PH_SPACE:  begin w_emit = 1'b1; w_code = ST_BAD_MARK;  end
                        PH_URLTOP: begin w_emit = 1'b1; w_code = ST_NO_URLTOP; end
                        PH_URL:    begin w_emit = 1'b1; w_code = ST_NO_URL;    end
                        PH_TITLE:  begin w_emit = 1'b1; w_code = ST_NO_TITLE;  end
                        PH_TIME:   begin w_emit = 1'b1; w_code = ST_NO_TIME;   end
                        PH_BODY:   begin w_emit = 1'b1; w_code = ST_NO_EOD;    end
                        PH_TAIL: begin
                            w_emit = 1'b1;
                            w_ok   = 1'b1;
                            w_late = 1'b1;
                        end
                        default: begin
                            w_emit = 1'b0;
                        end
                    endcase
                end
                n_phase = PH_HASH;
                n_eod   = '0;
                n_field = '0;
                n_pos   = '0;
            end else begin
                n_pos = r_pos + P'(1);
            end

            if (w_ok) begin
                n_cnt = r_cnt + ID'(1);
            end
        end
    end

    // record end is pos+1 (pos+2 when the buffer stops right after EOD)
    assign w_bsize = r_pos - r_body - (w_late ? P'(3) : P'(4));
    assign w_rsize = r_pos - r_origin + (w_late ? P'(2) : P'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HASH;
            r_pos    <= '0;
            r_origin <= '0;
            r_cnt    <= '0;
            r_field  <= '0;
            r_ut     <= '0;
            r_u      <= '0;
            r_t      <= '0;
            r_acc    <= '0;
            r_ts     <= TS_BLANK;
            r_neg    <= 1'b0;
            r_body   <= '0;
            r_eod    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_origin <= n_origin;
            r_cnt    <= n_cnt;
            r_field  <= n_field;
            r_ut     <= n_ut;
            r_u      <= n_u;
            r_t      <= n_t;
            r_acc    <= n_acc;
            r_ts     <= n_ts;
            r_neg    <= n_neg;
            r_body   <= n_body;
            r_eod    <= n_eod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_emit) begin
            r_o_status <= w_ok ? ST_OK : w_code;
            r_o_id     <= r_cnt;
            r_o_start  <= n_origin;
            r_o_ut     <= w_ok ? r_ut    : '0;
            r_o_u      <= w_ok ? r_u     : '0;
            r_o_t      <= w_ok ? r_t     : '0;
            r_o_time   <= w_ok ? r_acc   : 32'd0;
            r_o_bstart <= w_ok ? r_body  : '0;
            r_o_bsize  <= w_ok ? w_bsize : '0;
            r_o_rsize  <= w_ok ? w_rsize : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_record_id     = r_o_id;
    assign o_record_start  = r_o_start;
    assign o_urltop_length = r_o_ut;
    assign o_url_length    = r_o_u;
    assign o_title_length  = r_o_t;
    assign o_fetch_time    = r_o_time;
    assign o_body_start    = r_o_bstart;
    assign o_body_len      = r_o_bsize;
    assign o_record_size   = r_o_rsize;

endmodule
